@@ rtl/atrp_pkg.sv @@
package atrp_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int GUARD_BITS = 8;
  localparam int IANG_FRAC = 20;
  localparam int ANG_W = 32;
  localparam int TABLE_LEN = 24;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  function automatic logic [ANG_W-1:0] atan_q20(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0: v = 32'd47185920;
      5'd1: v = 32'd27855475;
      5'd2: v = 32'd14718068;
      5'd3: v = 32'd7471121;
      5'd4: v = 32'd3750058;
      5'd5: v = 32'd1876857;
      5'd6: v = 32'd938658;
      5'd7: v = 32'd469357;
      5'd8: v = 32'd234682;
      5'd9: v = 32'd117342;
      5'd10: v = 32'd58671;
      5'd11: v = 32'd29335;
      5'd12: v = 32'd14668;
      5'd13: v = 32'd7334;
      5'd14: v = 32'd3667;
      5'd15: v = 32'd1833;
      5'd16: v = 32'd917;
      5'd17: v = 32'd458;
      5'd18: v = 32'd229;
      5'd19: v = 32'd115;
      5'd20: v = 32'd57;
      5'd21: v = 32'd29;
      5'd22: v = 32'd14;
      5'd23: v = 32'd7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

@@ rtl/atrp_cordic.sv @@
module atrp_cordic import atrp_pkg::*; #(
  parameter int VW = 28,
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [VW-1:0]    in_x,
  input  logic signed [VW-1:0]    in_y,
  input  logic signed [ANG_W-1:0] in_a,
  output logic                    out_valid,
  output logic signed [VW-1:0]    out_x,
  output logic signed [ANG_W-1:0] out_a
);
  localparam int N = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
  logic                    v_r [N+1];
  logic signed [VW-1:0]    x_r [N+1];
  logic signed [VW-1:0]    y_r [N+1];
  logic signed [ANG_W-1:0] a_r [N+1];

  always_comb begin
    v_r[0] = in_valid;
    x_r[0] = in_x;
    y_r[0] = in_y;
    a_r[0] = in_a;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic signed [VW-1:0] x_nxt, y_nxt;
    logic signed [ANG_W-1:0] a_nxt;
    always_comb begin
      if (!y_r[i][VW-1]) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        a_nxt = a_r[i] + signed'(atan_q20(5'(i)));
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        a_nxt = a_r[i] - signed'(atan_q20(5'(i)));
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
      if (adv) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        a_r[i+1] <= a_nxt;
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_x = x_r[N];
  assign out_a = a_r[N];
endmodule

@@ rtl/accel_tilt_roll_pitch.sv @@
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_chip_x, in_chip_y, in_chip_z
// out     | out_valid | out_stall | out_roll_deg, out_pitch_deg
// One word per cycle unless stalled; 2*min(CORDIC_STAGES,24)+3 register stages deep.
// Depth set by two chained pipelined CORDIC vectoring units, one stage per iteration.
// Synchronous active-low reset clears all valid bits.
// Whole pipeline freezes while out_valid is high and out_stall is high.
module accel_tilt_roll_pitch import atrp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_chip_x,
  input  logic signed [SAMPLE_BITS-1:0]   in_chip_y,
  input  logic signed [SAMPLE_BITS-1:0]   in_chip_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ANGLE_FRAC_BITS+8:0] out_roll_deg,
  output logic signed [ANGLE_FRAC_BITS+7:0] out_pitch_deg
);
  localparam int VW = SAMPLE_BITS + GUARD_BITS + 4;
  localparam int RW = ANGLE_FRAC_BITS + 9;
  localparam int PW = ANGLE_FRAC_BITS + 8;
  localparam int SH = IANG_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] I90 = ANG_W'(90) <<< IANG_FRAC;
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (SH - 1);
  localparam logic signed [ANG_W-1:0] RLIM = ANG_W'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] PLIM = ANG_W'(90) <<< ANGLE_FRAC_BITS;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 0: remap, prerotate
  logic v0_r, zero0_r, xpos0_r;
  logic signed [VW-1:0] x0_r, y0_r, p0_r;
  logic signed [ANG_W-1:0] a0_r;
  logic signed [VW-1:0] ex, ey, ez;
  assign ex = VW'(in_chip_z) <<< GUARD_BITS;
  assign ey = VW'(in_chip_y) <<< GUARD_BITS;
  assign ez = VW'(in_chip_x) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
    if (adv) begin
      zero0_r <= (in_chip_y == '0) && (in_chip_x == '0);
      xpos0_r <= !in_chip_z[SAMPLE_BITS-1] && (in_chip_z != '0);
      p0_r <= -ex;
      if (ez[VW-1]) begin
        if (!ey[VW-1]) begin
          x0_r <= ey; y0_r <= -ez; a0_r <= I90;
        end else begin
          x0_r <= -ey; y0_r <= ez; a0_r <= -I90;
        end
      end else begin
        x0_r <= ez; y0_r <= ey; a0_r <= '0;
      end
    end
  end

  localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  // side data delay line alongside first CORDIC
  logic zero_d [N+1];
  logic xpos_d [N+1];
  logic signed [VW-1:0] p_d [N+1];
  always_comb begin
    zero_d[0] = zero0_r; xpos_d[0] = xpos0_r; p_d[0] = p0_r;
  end
  for (genvar i = 0; i < N; i++) begin : g_d
    always_ff @(posedge clk) if (adv) begin
      zero_d[i+1] <= zero_d[i]; xpos_d[i+1] <= xpos_d[i]; p_d[i+1] <= p_d[i];
    end
  end

  logic c1_v;
  logic signed [VW-1:0] c1_x;
  logic signed [ANG_W-1:0] c1_a;
  atrp_cordic #(.VW(VW), .STAGES(CORDIC_STAGES)) u_c1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v0_r), .in_x(x0_r), .in_y(y0_r),
    .in_a(a0_r), .out_valid(c1_v), .out_x(c1_x), .out_a(c1_a)
  );

  // stage g: gain multiply, roll round and clamp
  logic v1_r, zero1_r, xpos1_r;
  logic signed [VW-1:0] p1_r;
  logic [VW+29:0] prod1_r;
  logic signed [ANG_W-1:0] roll1_r;
  logic signed [ANG_W-1:0] rr;
  logic [VW-1:0] mag;
  assign mag = (!c1_x[VW-1] && c1_x != '0) ? c1_x : '0;
  assign rr = (-c1_a + HALF) >>> SH;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= c1_v;
    if (adv) begin
      zero1_r <= zero_d[N]; xpos1_r <= xpos_d[N]; p1_r <= p_d[N];
      prod1_r <= (VW+30)'(mag) * (VW+30)'(INV_GAIN_Q30);
      roll1_r <= zero_d[N] ? '0 : (rr > RLIM ? RLIM : (rr < -RLIM ? -RLIM : rr));
    end
  end

  logic signed [VW-1:0] hyp;
  assign hyp = VW'(prod1_r >> 30);

  logic zero_e [N+1];
  logic xpos_e [N+1];
  logic signed [ANG_W-1:0] roll_e [N+1];
  always_comb begin
    zero_e[0] = zero1_r; xpos_e[0] = xpos1_r; roll_e[0] = roll1_r;
  end
  for (genvar i = 0; i < N; i++) begin : g_e
    always_ff @(posedge clk) if (adv) begin
      zero_e[i+1] <= zero_e[i]; xpos_e[i+1] <= xpos_e[i]; roll_e[i+1] <= roll_e[i];
    end
  end

  logic c2_v;
  logic signed [VW-1:0] c2_x;
  logic signed [ANG_W-1:0] c2_a;
  atrp_cordic #(.VW(VW), .STAGES(CORDIC_STAGES)) u_c2 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v1_r), .in_x(hyp), .in_y(p1_r),
    .in_a('0), .out_valid(c2_v), .out_x(c2_x), .out_a(c2_a)
  );

  logic signed [ANG_W-1:0] pr;
  assign pr = (c2_a + HALF) >>> SH;
  logic v2_r;
  logic signed [RW-1:0] roll2_r;
  logic signed [PW-1:0] pitch2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= c2_v;
    if (adv) begin
      roll2_r <= RW'(roll_e[N]);
      if (zero_e[N]) pitch2_r <= xpos_e[N] ? PW'(PLIM) : PW'(-PLIM);
      else pitch2_r <= PW'(pr > PLIM ? PLIM : (pr < -PLIM ? -PLIM : pr));
    end
  end

  assign out_valid = v2_r;
  assign out_roll_deg = roll2_r;
  assign out_pitch_deg = pitch2_r;
endmodule

@@ rtl/atrp_checker.sv @@
module atrp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [16:0] out_roll_deg,
  input logic signed [15:0] out_pitch_deg
);
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("in_stall mismatch");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("stalled input word dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_roll_deg) && $stable(out_pitch_deg))
    else $error("stalled word changed");
  a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_deg <= 17'sd46080 && out_roll_deg >= -17'sd46080)
    else $error("roll range");
  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_deg <= 16'sd23040 && out_pitch_deg >= -16'sd23040)
    else $error("pitch range");
endmodule

bind accel_tilt_roll_pitch atrp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_roll_deg(out_roll_deg), .out_pitch_deg(out_pitch_deg)
);
